// ===== src/ucesc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucesc_pkg
// Shared types, register indexes, character constants and helper functions
// for the Unicode character escaper.
// ----------------------------------------------------------------------------
package ucesc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ESCAPE_CONTROL  = 3'd0,
    CFG_ESCAPE_DQUOTE   = 3'd1,
    CFG_ESCAPE_SQUOTE   = 3'd2,
    CFG_ESCAPE_EXTENDED = 3'd3,
    CFG_ESCAPE_NONASCII = 3'd4,
    CFG_JSON_MODE       = 3'd5,
    CFG_DROP_IGNORABLES = 3'd6,
    CFG_EMOJI_ZWSP      = 3'd7
  } cfg_idx_e;

  // Width classes supplied with each code point
  typedef enum logic [1:0] {
    WC_OTHER     = 2'd0,
    WC_CONTROL   = 2'd1,
    WC_IGNORABLE = 2'd2,
    WC_EMOJI     = 2'd3
  } width_class_e;

  localparam int unsigned CpW      = 21;
  localparam int unsigned MaxBytes = 15;
  localparam int unsigned CntW     = 4;

  // Character constants
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] ZWSP_B0   = 8'hE2;
  localparam logic [7:0] ZWSP_B1   = 8'h80;
  localparam logic [7:0] ZWSP_B2   = 8'h8B;

  typedef struct packed {
    logic escape_control;
    logic escape_dquote;
    logic escape_squote;
    logic escape_extended;
    logic escape_nonascii;
    logic json_mode;
    logic drop_ignorables;
    logic emoji_zwsp;
  } cfg_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic [1:0]     width_class;
    logic           first_in_grapheme;
    logic           last_in_grapheme;
  } item_t;

  // Element i is the i-th byte sent
  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  typedef struct packed {
    byte_vec_t       bytes;
    logic [CntW-1:0] count;
    logic            seen_next;
  } render_res_t;

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else begin
      r = 8'h57 + {4'd0, d};
    end
    return r;
  endfunction

  // Letter of a C-style escape, zero where the control has none
  function automatic logic [7:0] ctl_letter(input logic [6:0] c, input logic json);
    logic [7:0] r;
    case (c)
      7'h07:   r = json ? 8'h00 : 8'h61;
      7'h08:   r = 8'h62;
      7'h0C:   r = 8'h66;
      7'h0A:   r = 8'h6E;
      7'h0D:   r = 8'h72;
      7'h09:   r = 8'h74;
      7'h0B:   r = json ? 8'h00 : 8'h76;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ucesc_if.sv =====
// ----------------------------------------------------------------------------
// ucesc channel interfaces
// Valid/ready channels for code points in, bytes out and configuration writes.
// ----------------------------------------------------------------------------
interface ucesc_in_if;
  logic                      valid;
  logic                      ready;
  logic [ucesc_pkg::CpW-1:0] code_point;
  logic [1:0]                width_class;
  logic                      first_in_grapheme;
  logic                      last_in_grapheme;

  modport source (output valid, code_point, width_class, first_in_grapheme,
                  last_in_grapheme, input ready);
  modport sink   (input valid, code_point, width_class, first_in_grapheme,
                  last_in_grapheme, output ready);
endinterface

interface ucesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface ucesc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/unicode_char_escaper_unit.sv =====
// ----------------------------------------------------------------------------
// unicode_char_escaper_unit
// Renders a stream of code points as escaped text or UTF-8, one byte per
// output transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                                     Per transaction
// in_chan   sink       code_point, width_class, first/last marks   one code point
// out_chan  source     out_byte, last_byte                         one byte
// cfg_chan  sink       index, data                                 one register write
//
// An accepted code point is rendered combinationally while it sits in the input
// register; its bytes then leave at one per cycle while out_chan is ready. A code
// point yields n (0..15) bytes, n set by the renderer, and its bytes load as the last byte of the one before is taken.
// Code points that produce no bytes pass without holding an output slot.
// Back-pressure on out_chan stalls the byte buffer, then the input register.
// Reset clears the configuration, the emoji flag and all valid flags.
// ----------------------------------------------------------------------------
module unicode_char_escaper_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  ucesc_in_if.sink          in_chan,
  ucesc_out_if.source       out_chan,
  ucesc_cfg_if.sink         cfg_chan
);

  ucesc_pkg::cfg_t            cfg_q;
  ucesc_pkg::item_t           item_q;
  logic                       item_vld_q;
  logic                       seen_q;
  ucesc_pkg::byte_vec_t       obuf_q;
  logic [ucesc_pkg::CntW-1:0] cnt_q;
  logic [ucesc_pkg::CntW-1:0] idx_q;
  logic                       obuf_vld_q;

  ucesc_pkg::render_res_t     res;
  logic                       in_acc, out_acc, out_last, obuf_free, adv, load;

  ucesc_render u_render (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .seen_i (seen_q),
    .res_o  (res)
  );

  // Handshake control
  assign out_last  = (idx_q == cnt_q - 4'd1);
  assign out_acc   = out_chan.valid && out_chan.ready;
  assign obuf_free = !obuf_vld_q || (out_acc && out_last);
  assign adv       = item_vld_q && ((res.count == '0) || obuf_free);
  assign load      = adv && (res.count != '0);
  assign in_acc    = in_chan.valid && in_chan.ready;

  assign in_chan.ready      = !item_vld_q || adv;
  assign cfg_chan.ready     = 1'b1;
  assign out_chan.valid     = obuf_vld_q;
  assign out_chan.out_byte  = obuf_q[idx_q];
  assign out_chan.last_byte = out_last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_chan.valid) begin
      case (ucesc_pkg::cfg_idx_e'(cfg_chan.index))
        ucesc_pkg::CFG_ESCAPE_CONTROL:  cfg_q.escape_control  <= cfg_chan.data;
        ucesc_pkg::CFG_ESCAPE_DQUOTE:   cfg_q.escape_dquote   <= cfg_chan.data;
        ucesc_pkg::CFG_ESCAPE_SQUOTE:   cfg_q.escape_squote   <= cfg_chan.data;
        ucesc_pkg::CFG_ESCAPE_EXTENDED: cfg_q.escape_extended <= cfg_chan.data;
        ucesc_pkg::CFG_ESCAPE_NONASCII: cfg_q.escape_nonascii <= cfg_chan.data;
        ucesc_pkg::CFG_JSON_MODE:       cfg_q.json_mode       <= cfg_chan.data;
        ucesc_pkg::CFG_DROP_IGNORABLES: cfg_q.drop_ignorables <= cfg_chan.data;
        ucesc_pkg::CFG_EMOJI_ZWSP:      cfg_q.emoji_zwsp      <= cfg_chan.data;
        default:                        cfg_q <= cfg_q;
      endcase
    end
  end

  // Input register control and emoji flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      seen_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (adv) begin
        item_vld_q <= 1'b0;
      end
      if (adv) begin
        seen_q <= res.seen_next;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.code_point        <= in_chan.code_point;
      item_q.width_class       <= in_chan.width_class;
      item_q.first_in_grapheme <= in_chan.first_in_grapheme;
      item_q.last_in_grapheme  <= in_chan.last_in_grapheme;
    end
  end

  // Byte buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_vld_q <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
    end else if (load) begin
      obuf_vld_q <= 1'b1;
      idx_q      <= '0;
      cnt_q      <= res.count;
    end else if (out_acc) begin
      if (out_last) begin
        obuf_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  // Byte buffer payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      obuf_q <= res.bytes;
    end
  end

endmodule

// ===== src/ucesc_render.sv =====
// ----------------------------------------------------------------------------
// ucesc_render
// Combinational rendering of one code point into up to fifteen output bytes,
// with the emoji grapheme tracking that follows from it.
// ----------------------------------------------------------------------------
module ucesc_render (
  input  ucesc_pkg::item_t       item_i,
  input  ucesc_pkg::cfg_t        cfg_i,
  input  logic                   seen_i,
  output ucesc_pkg::render_res_t res_o
);

  logic [ucesc_pkg::CpW-1:0]  cp;
  logic                       is_ascii, is_ctl, esc_any, ascii_esc;
  logic                       wide_esc, dropped, utf8_path;
  logic                       seen_eff, seen_after, zwsp;
  logic [7:0]                 letter;
  logic [ucesc_pkg::CpW-1:0]  t;
  logic [15:0]                sur_hi, sur_lo;
  logic [31:0]                cp32;
  ucesc_pkg::byte_vec_t       mb;
  logic [ucesc_pkg::CntW-1:0] mn;
  logic [ucesc_pkg::CntW-1:0] k;

  // Decode of the code point class
  always_comb begin
    cp        = item_i.code_point;
    is_ascii  = (cp[ucesc_pkg::CpW-1:7] == '0);
    is_ctl    = is_ascii && ((cp[6:5] == 2'b00) || (cp[6:0] == ucesc_pkg::CH_DEL[6:0]));
    esc_any   = cfg_i.escape_control | cfg_i.escape_dquote | cfg_i.escape_squote |
                cfg_i.escape_extended | cfg_i.escape_nonascii;
    ascii_esc = (is_ctl && cfg_i.escape_control) ||
                (cp[6:0] == ucesc_pkg::CH_DQUOTE[6:0] && cfg_i.escape_dquote) ||
                (cp[6:0] == ucesc_pkg::CH_SQUOTE[6:0] && cfg_i.escape_squote) ||
                (cp[6:0] == ucesc_pkg::CH_BSLASH[6:0] && esc_any);
    letter    = ucesc_pkg::ctl_letter(cp[6:0], cfg_i.json_mode);
    wide_esc  = cfg_i.escape_nonascii ||
                (cp[ucesc_pkg::CpW-1:16] != '0 && cfg_i.escape_extended) ||
                (item_i.width_class == ucesc_pkg::WC_CONTROL && cfg_i.escape_control);
    seen_eff  = item_i.first_in_grapheme ? 1'b0 : seen_i;
    dropped   = (item_i.width_class == ucesc_pkg::WC_IGNORABLE) &&
                cfg_i.drop_ignorables && !seen_eff;
    utf8_path = !is_ascii && !wide_esc && !dropped;
    seen_after = seen_eff || (utf8_path && item_i.width_class == ucesc_pkg::WC_EMOJI);
    zwsp      = item_i.last_in_grapheme && seen_after && cfg_i.emoji_zwsp;
    // surrogate pair halves, 16 bits each
    t         = cp - ucesc_pkg::CpW'(32'h10000);
    sur_hi    = 16'hD800 + {5'd0, t[20:10]};
    sur_lo    = {6'b110111, t[9:0]};
    cp32      = {11'd0, cp};
  end

  // Main byte sequence
  always_comb begin
    mb = '0;
    mn = '0;
    if (is_ascii) begin
      if (!ascii_esc) begin
        mb[0] = cp[7:0];
        mn    = 4'd1;
      end else if (is_ctl && letter == 8'h00) begin
        mb[0] = ucesc_pkg::CH_BSLASH;
        mb[1] = ucesc_pkg::CH_LC_U;
        mb[2] = ucesc_pkg::hex_char(4'd0);
        mb[3] = ucesc_pkg::hex_char(4'd0);
        mb[4] = ucesc_pkg::hex_char(cp[7:4]);
        mb[5] = ucesc_pkg::hex_char(cp[3:0]);
        mn    = 4'd6;
      end else begin
        mb[0] = ucesc_pkg::CH_BSLASH;
        mb[1] = is_ctl ? letter : cp[7:0];
        mn    = 4'd2;
      end
    end else if (wide_esc) begin
      if (cp[ucesc_pkg::CpW-1:16] == '0) begin
        mb[0] = ucesc_pkg::CH_BSLASH;
        mb[1] = ucesc_pkg::CH_LC_U;
        for (int i = 0; i < 4; i++) begin
          mb[2+i] = ucesc_pkg::hex_char(cp[15-4*i -: 4]);
        end
        mn = 4'd6;
      end else if (cfg_i.json_mode) begin
        mb[0] = ucesc_pkg::CH_BSLASH;
        mb[1] = ucesc_pkg::CH_LC_U;
        mb[6] = ucesc_pkg::CH_BSLASH;
        mb[7] = ucesc_pkg::CH_LC_U;
        for (int i = 0; i < 4; i++) begin
          mb[2+i] = ucesc_pkg::hex_char(sur_hi[15-4*i -: 4]);
          mb[8+i] = ucesc_pkg::hex_char(sur_lo[15-4*i -: 4]);
        end
        mn = 4'd12;
      end else begin
        mb[0] = ucesc_pkg::CH_BSLASH;
        mb[1] = ucesc_pkg::CH_UC_U;
        for (int i = 0; i < 8; i++) begin
          mb[2+i] = ucesc_pkg::hex_char(cp32[31-4*i -: 4]);
        end
        mn = 4'd10;
      end
    end else if (utf8_path) begin
      if (cp[ucesc_pkg::CpW-1:11] == '0) begin
        mb[0] = {3'b110, cp[10:6]};
        mb[1] = {2'b10, cp[5:0]};
        mn    = 4'd2;
      end else if (cp[ucesc_pkg::CpW-1:16] == '0) begin
        mb[0] = {4'b1110, cp[15:12]};
        mb[1] = {2'b10, cp[11:6]};
        mb[2] = {2'b10, cp[5:0]};
        mn    = 4'd3;
      end else begin
        mb[0] = {5'b11110, cp[20:18]};
        mb[1] = {2'b10, cp[17:12]};
        mb[2] = {2'b10, cp[11:6]};
        mb[3] = {2'b10, cp[5:0]};
        mn    = 4'd4;
      end
    end
  end

  // Append the zero width space after the main sequence
  always_comb begin
    res_o.bytes = '0;
    k           = '0;
    for (int i = 0; i < ucesc_pkg::MaxBytes; i++) begin
      k = 4'(i) - mn;
      if (4'(i) < mn) begin
        res_o.bytes[i] = mb[i];
      end else if (zwsp) begin
        case (k)
          4'd0:    res_o.bytes[i] = ucesc_pkg::ZWSP_B0;
          4'd1:    res_o.bytes[i] = ucesc_pkg::ZWSP_B1;
          4'd2:    res_o.bytes[i] = ucesc_pkg::ZWSP_B2;
          default: res_o.bytes[i] = 8'h00;
        endcase
      end
    end
    res_o.count     = mn + (zwsp ? 4'd3 : 4'd0);
    res_o.seen_next = item_i.last_in_grapheme ? 1'b0 : seen_after;
  end

endmodule

// ===== verif/unicode_char_escaper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// unicode_char_escaper_unit_tb
// Self-checking bench for the Unicode character escaper. Code points are fed
// from a backlog through the input channel, and each accepted transaction is
// rendered by a local byte-level predictor. Every output byte is compared in
// order against the predicted text. Register settings change between drained
// phases. Random gaps, random stalls and one long output hold-off are applied.
// ----------------------------------------------------------------------------
module unicode_char_escaper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 400;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  logic clk_i;
  logic rst_ni;

  ucesc_in_if  cp_if ();
  ucesc_out_if txt_if ();
  ucesc_cfg_if reg_if ();

  unicode_char_escaper_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (cp_if),
    .out_chan (txt_if),
    .cfg_chan (reg_if)
  );

  // Predictor state: register copy and emoji flag of the open grapheme
  ucesc_pkg::cfg_t  esc_cfg;
  logic             grapheme_has_emoji;

  ucesc_pkg::item_t cp_backlog[$];
  ucesc_pkg::item_t offered_cp;
  text_byte_t       expected_text[$];
  text_byte_t       exp_byte;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  int unsigned cps_accepted;
  int unsigned bytes_checked;
  int unsigned mismatches;
  int unsigned settings_applied;
  int unsigned hold_left;
  logic        hold_done;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Text predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'h0, d};
    end
    return 8'h61 + {4'h0, d} - 8'd10;
  endfunction

  function automatic void add_hex(ref octet_q_t q, input logic [31:0] v, input int digits);
    for (int i = digits - 1; i >= 0; i--) begin
      q.push_back(hex_digit(v[4*i +: 4]));
    end
  endfunction

  function automatic void add_u4(ref octet_q_t q, input logic [15:0] v);
    q.push_back(ucesc_pkg::CH_BSLASH);
    q.push_back(ucesc_pkg::CH_LC_U);
    add_hex(q, {16'h0, v}, 4);
  endfunction

  // Renders one code point and queues its bytes, last one flagged
  function automatic void render_code_point(input ucesc_pkg::item_t it);
    octet_q_t    txt;
    logic [20:0] cp;
    logic [31:0] ofs;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [7:0]  letter;
    logic        is_ctl;
    logic        any_esc;
    logic        esc_ascii;
    text_byte_t  tb;

    cp = it.code_point;
    if (it.first_in_grapheme) begin
      grapheme_has_emoji = 1'b0;
    end
    if (cp <= 21'h7F) begin
      // ASCII: width class plays no part
      is_ctl = (cp <= 21'h1F) || (cp[7:0] == ucesc_pkg::CH_DEL);
      any_esc = esc_cfg.escape_control | esc_cfg.escape_dquote | esc_cfg.escape_squote |
                esc_cfg.escape_extended | esc_cfg.escape_nonascii;
      esc_ascii = (is_ctl && esc_cfg.escape_control) ||
                  (cp[7:0] == ucesc_pkg::CH_DQUOTE && esc_cfg.escape_dquote) ||
                  (cp[7:0] == ucesc_pkg::CH_SQUOTE && esc_cfg.escape_squote) ||
                  (cp[7:0] == ucesc_pkg::CH_BSLASH && any_esc);
      if (!esc_ascii) begin
        txt.push_back(cp[7:0]);
      end else if (is_ctl) begin
        // C-style letters; bell and vertical tab fall back to \u in JSON
        case (cp[6:0])
          7'h07:   letter = esc_cfg.json_mode ? 8'h00 : 8'h61;
          7'h08:   letter = 8'h62;
          7'h09:   letter = 8'h74;
          7'h0A:   letter = 8'h6E;
          7'h0B:   letter = esc_cfg.json_mode ? 8'h00 : 8'h76;
          7'h0C:   letter = 8'h66;
          7'h0D:   letter = 8'h72;
          default: letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
          txt.push_back(ucesc_pkg::CH_BSLASH);
          txt.push_back(letter);
        end else begin
          add_u4(txt, {8'h00, cp[7:0]});
        end
      end else begin
        txt.push_back(ucesc_pkg::CH_BSLASH);
        txt.push_back(cp[7:0]);
      end
    end else if (esc_cfg.escape_nonascii || (cp > 21'hFFFF && esc_cfg.escape_extended) ||
                 (it.width_class == ucesc_pkg::WC_CONTROL && esc_cfg.escape_control)) begin
      // Wide escapes
      if (cp <= 21'hFFFF) begin
        add_u4(txt, cp[15:0]);
      end else if (esc_cfg.json_mode) begin
        ofs = {11'h0, cp} - 32'h10000;
        hi  = 32'hD800 + (ofs >> 10);
        lo  = 32'hDC00 + {22'h0, cp[9:0]};
        add_u4(txt, hi[15:0]);
        add_u4(txt, lo[15:0]);
      end else begin
        txt.push_back(ucesc_pkg::CH_BSLASH);
        txt.push_back(ucesc_pkg::CH_UC_U);
        add_hex(txt, {11'h0, cp}, 8);
      end
    end else if (!(it.width_class == ucesc_pkg::WC_IGNORABLE && esc_cfg.drop_ignorables &&
                   !grapheme_has_emoji)) begin
      // Plain UTF-8; only an unescaped emoji marks the grapheme
      if (it.width_class == ucesc_pkg::WC_EMOJI) begin
        grapheme_has_emoji = 1'b1;
      end
      if (cp <= 21'h7FF) begin
        txt.push_back({3'b110, cp[10:6]});
        txt.push_back({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
        txt.push_back({4'b1110, cp[15:12]});
        txt.push_back({2'b10, cp[11:6]});
        txt.push_back({2'b10, cp[5:0]});
      end else begin
        txt.push_back({5'b11110, cp[20:18]});
        txt.push_back({2'b10, cp[17:12]});
        txt.push_back({2'b10, cp[11:6]});
        txt.push_back({2'b10, cp[5:0]});
      end
    end
    // Grapheme end: optional zero width space after an emoji
    if (it.last_in_grapheme) begin
      if (grapheme_has_emoji && esc_cfg.emoji_zwsp) begin
        txt.push_back(ucesc_pkg::ZWSP_B0);
        txt.push_back(ucesc_pkg::ZWSP_B1);
        txt.push_back(ucesc_pkg::ZWSP_B2);
      end
      grapheme_has_emoji = 1'b0;
    end
    for (int k = 0; k < txt.size() && k < ucesc_pkg::MaxBytes; k++) begin
      tb.data = txt[k];
      tb.last = (k == txt.size() - 1) || (k == ucesc_pkg::MaxBytes - 1);
      expected_text.push_back(tb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cp_if.valid <= 1'b0;
    end else begin
      if (cp_if.valid && cp_if.ready) begin
        render_code_point(offered_cp);
        cps_accepted++;
      end
      if (!cp_if.valid || cp_if.ready) begin
        if (cp_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          offered_cp = cp_backlog.pop_front();
          cp_if.code_point        <= offered_cp.code_point;
          cp_if.width_class       <= offered_cp.width_class;
          cp_if.first_in_grapheme <= offered_cp.first_in_grapheme;
          cp_if.last_in_grapheme  <= offered_cp.last_in_grapheme;
          cp_if.valid             <= 1'b1;
        end else begin
          cp_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      txt_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (txt_if.valid && txt_if.ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected byte, expected none, actual %h last %b", $time,
                   txt_if.out_byte, txt_if.last_byte);
        end else begin
          exp_byte = expected_text.pop_front();
          bytes_checked++;
          if (txt_if.out_byte !== exp_byte.data) begin
            mismatches++;
            $display("%0t: out_byte expected %h actual %h", $time, exp_byte.data,
                     txt_if.out_byte);
          end
          if (txt_if.last_byte !== exp_byte.last) begin
            mismatches++;
            $display("%0t: last_byte expected %b actual %b", $time, exp_byte.last,
                     txt_if.last_byte);
          end
        end
      end
      // One long hold-off while the sender still has plenty queued
      if (!hold_done && cps_accepted >= 50 && cp_backlog.size() > 20) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        txt_if.ready <= 1'b0;
      end else begin
        txt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("unicode_char_escaper_unit_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input ucesc_pkg::cfg_idx_e idx, input logic val);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    case (idx)
      ucesc_pkg::CFG_ESCAPE_CONTROL:  esc_cfg.escape_control  = val;
      ucesc_pkg::CFG_ESCAPE_DQUOTE:   esc_cfg.escape_dquote   = val;
      ucesc_pkg::CFG_ESCAPE_SQUOTE:   esc_cfg.escape_squote   = val;
      ucesc_pkg::CFG_ESCAPE_EXTENDED: esc_cfg.escape_extended = val;
      ucesc_pkg::CFG_ESCAPE_NONASCII: esc_cfg.escape_nonascii = val;
      ucesc_pkg::CFG_JSON_MODE:       esc_cfg.json_mode       = val;
      ucesc_pkg::CFG_DROP_IGNORABLES: esc_cfg.drop_ignorables = val;
      ucesc_pkg::CFG_EMOJI_ZWSP:      esc_cfg.emoji_zwsp      = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input ucesc_pkg::cfg_t s);
    write_reg(ucesc_pkg::CFG_ESCAPE_CONTROL,  s.escape_control);
    write_reg(ucesc_pkg::CFG_ESCAPE_DQUOTE,   s.escape_dquote);
    write_reg(ucesc_pkg::CFG_ESCAPE_SQUOTE,   s.escape_squote);
    write_reg(ucesc_pkg::CFG_ESCAPE_EXTENDED, s.escape_extended);
    write_reg(ucesc_pkg::CFG_ESCAPE_NONASCII, s.escape_nonascii);
    write_reg(ucesc_pkg::CFG_JSON_MODE,       s.json_mode);
    write_reg(ucesc_pkg::CFG_DROP_IGNORABLES, s.drop_ignorables);
    write_reg(ucesc_pkg::CFG_EMOJI_ZWSP,      s.emoji_zwsp);
    settings_applied++;
  endtask

  // Block idle: nothing queued, offered or owed, plus slack for byteless items
  task automatic wait_drained();
    while (cp_backlog.size() > 0 || cp_if.valid || expected_text.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_cp(input logic [20:0] cp, input ucesc_pkg::width_class_e wc,
                          input logic first, input logic last);
    ucesc_pkg::item_t it;
    it.code_point        = cp;
    it.width_class       = wc;
    it.first_in_grapheme = first;
    it.last_in_grapheme  = last;
    cp_backlog.push_back(it);
  endtask

  function automatic logic [20:0] pick_cp();
    logic [31:0] r;
    case ($urandom_range(8))
      0: r = ($urandom_range(3) == 0) ? 32'h7F : $urandom_range(31);
      1: begin
        case ($urandom_range(2))
          0:       r = {24'h0, ucesc_pkg::CH_DQUOTE};
          1:       r = {24'h0, ucesc_pkg::CH_SQUOTE};
          default: r = {24'h0, ucesc_pkg::CH_BSLASH};
        endcase
      end
      2: r = $urandom_range(126, 32);
      3: r = $urandom_range(32'h7FF, 32'h80);
      4: r = $urandom_range(32'hFFFF, 32'h800);
      5: r = $urandom_range(32'hDFFF, 32'hD800);
      6: r = $urandom_range(32'h10FFFF, 32'h10000);
      7: r = $urandom_range(32'h1FFFFF, 32'h110000);
      default: r = $urandom();
    endcase
    return r[20:0];
  endfunction

  // Mostly well-formed graphemes, some emoji sequences, some noise
  task automatic queue_random(input int unsigned n);
    int unsigned queued;
    int unsigned len;
    int unsigned kind;
    logic [31:0] r;
    queued = 0;
    while (queued < n) begin
      kind = $urandom_range(99);
      len  = $urandom_range(4, 1);
      if (kind < 15) begin
        r = $urandom();
        queue_cp(r[20:0], ucesc_pkg::width_class_e'(r[22:21]), r[23], r[24]);
        len = 1;
      end else if (kind < 45) begin
        // emoji joined by ignorables
        for (int k = 0; k < len; k++) begin
          if (k % 2 == 0) begin
            r = $urandom_range(32'h1FAFF, 32'h1F300);
            queue_cp(r[20:0], ucesc_pkg::WC_EMOJI, k == 0, k == len - 1);
          end else begin
            queue_cp(($urandom_range(1) == 0) ? 21'h200D : 21'hFE0F,
                     ucesc_pkg::WC_IGNORABLE, 1'b0, k == len - 1);
          end
        end
      end else begin
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(3);
          queue_cp(pick_cp(), ucesc_pkg::width_class_e'(r[1:0]), k == 0, k == len - 1);
        end
      end
      queued += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    ucesc_pkg::cfg_t setting;
    logic [31:0]     rnd;

    rst_ni                  = 1'b0;
    cp_if.valid             = 1'b0;
    cp_if.code_point        = '0;
    cp_if.width_class       = '0;
    cp_if.first_in_grapheme = 1'b0;
    cp_if.last_in_grapheme  = 1'b0;
    txt_if.ready            = 1'b0;
    reg_if.valid            = 1'b0;
    reg_if.index            = ucesc_pkg::CFG_ESCAPE_CONTROL;
    reg_if.data             = 1'b0;
    esc_cfg                 = '0;
    grapheme_has_emoji      = 1'b0;
    cycle_count             = 0;
    cps_accepted            = 0;
    bytes_checked           = 0;
    mismatches              = 0;
    settings_applied        = 0;
    send_gap_pct            = 15;
    recv_stall_pct          = 15;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: C escapes, \u00xx, quotes, backslash, wide escapes, dropping
    setting = '0;
    setting.escape_control  = 1'b1;
    setting.escape_dquote   = 1'b1;
    setting.escape_squote   = 1'b1;
    setting.escape_extended = 1'b1;
    setting.drop_ignorables = 1'b1;
    setting.emoji_zwsp      = 1'b1;
    apply_setting(setting);
    queue_cp(21'h07, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h08, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h09, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h0A, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h0B, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h0C, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h0D, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h00, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h7F, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h22, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h27, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h5C, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h41, ucesc_pkg::WC_EMOJI, 1'b1, 1'b1);
    queue_cp(21'h85, ucesc_pkg::WC_CONTROL, 1'b1, 1'b1);
    queue_cp(21'h1FFFFF, ucesc_pkg::WC_EMOJI, 1'b1, 1'b1);
    queue_cp(21'h200B, ucesc_pkg::WC_IGNORABLE, 1'b1, 1'b1);
    wait_drained();

    // Directed: JSON controls, emoji grapheme with ZWSP, surrogates, UTF-8
    setting = '0;
    setting.escape_control  = 1'b1;
    setting.json_mode       = 1'b1;
    setting.drop_ignorables = 1'b1;
    setting.emoji_zwsp      = 1'b1;
    apply_setting(setting);
    queue_cp(21'h07, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h0B, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h5C, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h1F468, ucesc_pkg::WC_EMOJI, 1'b1, 1'b0);
    queue_cp(21'h200D, ucesc_pkg::WC_IGNORABLE, 1'b0, 1'b0);
    queue_cp(21'h1F469, ucesc_pkg::WC_EMOJI, 1'b0, 1'b1);
    queue_cp(21'hFE0F, ucesc_pkg::WC_IGNORABLE, 1'b1, 1'b1);
    queue_cp(21'hD800, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h7FF, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'h1FFFFF, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    wait_drained();

    // Directed: everything non-ASCII escaped, surrogate pairs
    setting = '0;
    setting.escape_nonascii = 1'b1;
    setting.json_mode       = 1'b1;
    apply_setting(setting);
    queue_cp(21'h1F600, ucesc_pkg::WC_EMOJI, 1'b1, 1'b1);
    queue_cp(21'h1FFFFF, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    queue_cp(21'hFFFF, ucesc_pkg::WC_OTHER, 1'b1, 1'b1);
    wait_drained();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      rnd = $urandom();
      case (ph)
        1:       setting = '1;
        2:       setting = '0;
        default: setting = rnd[7:0];
      endcase
      // Middle phase runs without gaps or stalls
      send_gap_pct   = (ph == 2) ? 0 : 15;
      recv_stall_pct = (ph == 2) ? 0 : 15;
      apply_setting(setting);
      queue_random(65);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Run covered %0d code points and %0d output bytes over %0d register settings",
             cps_accepted, bytes_checked, settings_applied);
    $display("with %0d expected bytes outstanding and %0d mismatches",
             expected_text.size(), mismatches);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("unicode_char_escaper_unit_tb passed");
    end else begin
      $display("unicode_char_escaper_unit_tb failed");
    end
    $finish;
  end

endmodule
